### hw/rtl/rcpf_pkg.sv
// Shared types and constants for the RC pulse capture filter.
`default_nettype none

package rcpf_pkg;

  localparam int unsigned PINS        = 8;
  localparam int unsigned PIN_W       = 3;
  localparam int unsigned STAMP_W     = 16;
  localparam int unsigned RAW_W       = 12;
  localparam int unsigned OUT_CH_W    = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QCNT_W      = 2;

  localparam logic [15:0]      MIN_WIDTH_RST    = 16'd900;
  localparam logic [15:0]      MAX_WIDTH_RST    = 16'd2200;
  localparam logic [PINS-1:0]  ENABLED_PINS_RST = 8'hFF;
  localparam logic [23:0]      CHANNEL_MAP_RST  = 24'd16434824;
  localparam logic [RAW_W-1:0] RAW_RST          = 12'd1502;
  localparam logic [RAW_W-1:0] RAW_MAX          = 12'd4095;
  localparam logic [RAW_W:0]   DEADBAND         = 13'd3;
  localparam logic [RAW_W:0]   DB_STEP          = 13'd2;

  typedef enum logic [0:0] {
    OP_EDGE = 1'b0,
    OP_TICK = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_WIDTH    = 2'd0,
    CFG_MAX_WIDTH    = 2'd1,
    CFG_ENABLED_PINS = 2'd2,
    CFG_CHANNEL_MAP  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_MUL,
    BK_WRITE
  } back_state_e;

  typedef struct packed {
    opcode_e            opcode;
    logic [PINS-1:0]    pin_levels;
    logic [STAMP_W-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [OUT_CH_W-1:0] channel;
    logic [RAW_W-1:0]    value;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic [15:0]     min_width;
    logic [15:0]     max_width;
    logic [PINS-1:0] enabled_pins;
    logic [23:0]     channel_map;
  } cfg_t;

  // Decoded work for the back end.
  typedef struct packed {
    logic               tick;
    logic [PINS-1:0]    rise;
    logic [PINS-1:0]    fall;
    logic [STAMP_W-1:0] stamp;
  } op_t;

endpackage

`default_nettype wire

### hw/rtl/rcpf_front.sv
// Front end: accepts input beats and turns pin levels into rise/fall masks.
`default_nettype none

module rcpf_front import rcpf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     in_valid_i,
  input  wire in_item_t in_data_i,
  input  wire logic     q_full_i,
  output logic          in_stall_o,
  output logic          push_o,
  output op_t           op_o
);

  logic [PINS-1:0] prev_levels_q, prev_levels_d;
  logic [PINS-1:0] changed;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  always_comb begin
    changed       = (in_data_i.pin_levels ^ prev_levels_q) & cfg_i.enabled_pins;
    op_o.tick     = (in_data_i.opcode == OP_TICK);
    op_o.rise     = changed & in_data_i.pin_levels;
    op_o.fall     = changed & ~in_data_i.pin_levels;
    op_o.stamp    = in_data_i.timestamp;
    prev_levels_d = prev_levels_q;
    if (push_o && in_data_i.opcode == OP_EDGE) begin
      prev_levels_d = in_data_i.pin_levels;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_levels_q <= '0;
    end else begin
      prev_levels_q <= prev_levels_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rcpf_queue.sv
// Two-entry op queue between front and back end.
`default_nettype none

module rcpf_queue import rcpf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire op_t         data_i,
  input  wire logic        pop_i,
  output logic             full_o,
  output logic             valid_o,
  output op_t              data_o,
  output logic [QCNT_W-1:0] count_o
);

  op_t                 ent_q [QUEUE_DEPTH];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = ent_q[rd_ptr_q];
  assign count_o = cnt_q;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rcpf_back.sv
// Back end: edge capture state, per-channel moving average and deadband.
`default_nettype none

module rcpf_back import rcpf_pkg::*; #(
  parameter int unsigned CHANNELS = 8,
  parameter int unsigned WINDOW   = 4
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire logic      op_valid_i,
  input  wire op_t       op_i,
  output logic           op_pop_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  localparam int unsigned HIST    = WINDOW - 1;
  localparam int unsigned HDEPTH  = CHANNELS * HIST;
  localparam int unsigned ADDR_W  = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int unsigned SLOT_W  = (HIST > 1) ? $clog2(HIST) : 1;
  localparam int unsigned CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SUM_W   = $clog2(WINDOW * 4096);
  localparam int unsigned SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int unsigned RECIP_W = SHIFT + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  // ceil(2^SHIFT / WINDOW): exact quotient for any sum below 2^SUM_W
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << SHIFT) + WINDOW - 1) / WINDOW);
  localparam logic [SUM_W-1:0]   HALF  = SUM_W'(WINDOW / 2);

  back_state_e state_q, state_d;
  logic [CH_W-1:0]   ch_q, ch_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic [STAMP_W-1:0] rise_time_q [PINS];
  logic [RAW_W-1:0]   raw_q       [PINS];
  logic [RAW_W-1:0]   filt_q      [CHANNELS];
  logic [SUM_W-1:0]   hsum_q      [CHANNELS];
  logic [HDEPTH-1:0]  hist_vld_q;
  logic [RAW_W-1:0]   hist_mem    [HDEPTH];
  logic [RAW_W-1:0]   hist_rd_q;
  logic               hist_rd_vld_q;

  logic [SUM_W-1:0]  sum_q;
  logic [RAW_W-1:0]  cur_raw_q;
  logic [PROD_W-1:0] prod_q;

  logic        out_valid_q;
  out_item_t   out_data_q;

  logic              edge_exec, out_load;
  logic [ADDR_W-1:0] addr;
  logic [PIN_W-1:0]  pin;
  logic [RAW_W-1:0]  mean, old, filt_new;
  logic [RAW_W:0]    m13, c13;
  logic [STAMP_W-1:0] width [PINS];
  logic [PINS-1:0]    keep;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign addr = ADDR_W'(int'(ch_q) * HIST + int'(slot_q));
  assign pin  = cfg_i.channel_map[int'(ch_q) * PIN_W +: PIN_W];

  always_comb begin
    for (int p = 0; p < PINS; p++) begin
      width[p] = op_i.stamp - rise_time_q[p];
      keep[p]  = (width[p] > cfg_i.min_width) && (width[p] < cfg_i.max_width);
    end
  end

  // Mean, then deadband around the last filtered value
  always_comb begin
    mean = prod_q[SHIFT +: RAW_W];
    old  = hist_rd_vld_q ? hist_rd_q : '0;
    m13  = {1'b0, mean};
    c13  = {1'b0, filt_q[ch_q]};
    if (m13 + DEADBAND < c13) begin
      filt_new = RAW_W'(m13 + DB_STEP);
    end else if (m13 > c13 + DEADBAND) begin
      filt_new = RAW_W'(m13 - DB_STEP);
    end else begin
      filt_new = filt_q[ch_q];
    end
  end

  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    slot_d    = slot_q;
    op_pop_o  = 1'b0;
    edge_exec = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          if (op_i.tick) begin
            slot_d  = (slot_q == SLOT_W'(HIST - 1)) ? '0 : slot_q + SLOT_W'(1);
            ch_d    = '0;
            state_d = BK_READ;
          end else begin
            edge_exec = 1'b1;
          end
        end
      end
      BK_READ:  state_d = BK_MUL;
      BK_MUL:   state_d = BK_WRITE;
      BK_WRITE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          if (ch_q == CH_W'(CHANNELS - 1)) begin
            state_d = BK_IDLE;
          end else begin
            ch_d    = ch_q + CH_W'(1);
            state_d = BK_READ;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      ch_q        <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      hist_vld_q  <= '0;
      for (int p = 0; p < PINS; p++) begin
        rise_time_q[p] <= '0;
        raw_q[p]       <= RAW_RST;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        filt_q[c] <= '0;
        hsum_q[c] <= '0;
      end
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      slot_q      <= slot_d;
      out_valid_q <= out_load | (out_valid_q & out_stall_i);
      if (edge_exec) begin
        for (int p = 0; p < PINS; p++) begin
          if (op_i.rise[p]) begin
            rise_time_q[p] <= op_i.stamp;
          end else if (op_i.fall[p] && keep[p]) begin
            raw_q[p] <= (width[p] > STAMP_W'(RAW_MAX)) ? RAW_MAX : width[p][RAW_W-1:0];
          end
        end
      end
      if (out_load) begin
        filt_q[ch_q]     <= filt_new;
        hsum_q[ch_q]     <= hsum_q[ch_q] + SUM_W'(cur_raw_q) - SUM_W'(old);
        hist_vld_q[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_READ) begin
      hist_rd_q     <= hist_mem[addr];
      hist_rd_vld_q <= hist_vld_q[addr];
      sum_q         <= SUM_W'(raw_q[pin]) + hsum_q[ch_q];
      cur_raw_q     <= raw_q[pin];
    end
    if (state_q == BK_MUL) begin
      prod_q <= PROD_W'(sum_q + HALF) * PROD_W'(RECIP);
    end
    if (out_load) begin
      hist_mem[addr]     <= cur_raw_q;
      out_data_q.channel <= OUT_CH_W'(ch_q);
      out_data_q.value   <= filt_new;
      out_data_q.last    <= (ch_q == CH_W'(CHANNELS - 1));
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rc_pulse_capture_filter_top.sv
// Top level of the RC pulse capture filter: config registers, front, queue, back end.
`default_nettype none

// Servo pulse capture on eight pins with a per-channel moving average and
// deadband. An edge beat (opcode edge) carries the pin levels and a 16-bit
// microsecond time; enabled pins that rose record the time, pins that fell
// store the wrapped width as the raw width when it lies strictly between
// min_width and max_width (saturated to 4095). An edge beat gives no result.
// A tick beat advances the shared history slot and gives CHANNELS result
// beats in channel order, the last one flagged by last.
// Timing: the front takes a beat in the same cycle it arrives unless the
// two-entry op queue is full. The back end takes an edge in its idle state
// and walks a tick through select, multiply and write steps per channel, the
// write held while the result register is stalled. The history store is a
// CHANNELS*(WINDOW-1) entry memory with one read and one write per channel;
// per-channel running sums avoid summing the window. Config writes must only
// happen while the block is idle.
module rc_pulse_capture_filter_top import rcpf_pkg::*; #(
  parameter int unsigned CHANNELS = 8,
  parameter int unsigned WINDOW   = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_data_i,
  // result channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_data_o,
  // config write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t              cfg_q;
  op_t               push_op, q_op;
  logic              push, q_full, q_valid, q_pop;
  logic [QCNT_W-1:0] q_count;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_width    <= MIN_WIDTH_RST;
      cfg_q.max_width    <= MAX_WIDTH_RST;
      cfg_q.enabled_pins <= ENABLED_PINS_RST;
      cfg_q.channel_map  <= CHANNEL_MAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_WIDTH:    cfg_q.min_width    <= cfg_data_i[15:0];
        CFG_MAX_WIDTH:    cfg_q.max_width    <= cfg_data_i[15:0];
        CFG_ENABLED_PINS: cfg_q.enabled_pins <= cfg_data_i[PINS-1:0];
        CFG_CHANNEL_MAP:  cfg_q.channel_map  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // front: edge detect against previous levels
  rcpf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .op_o       (push_op)
  );

  // decouples edge capture from the slow tick walk
  rcpf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_op),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_op),
    .count_o (q_count)
  );

  rcpf_back #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_valid_i  (q_valid),
    .op_i        (q_op),
    .op_pop_o    (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // last flag only on the final channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.channel == OUT_CH_W'(CHANNELS - 1))
    else $error("last flag on wrong channel");

  // after a mid-tick beat, the next result shown is the following channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=>
      !out_valid_o || out_data_o.channel == $past(out_data_o.channel) + OUT_CH_W'(1))
    else $error("channel sequence broken");

  // a new tick restarts at channel zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.last |=>
      !out_valid_o || out_data_o.channel == '0)
    else $error("tick did not restart at channel zero");

  // queue occupancy never exceeds its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("op queue overflow");

endmodule

`default_nettype wire
